### design/pi_aqm_drop_controller_unit_assert.svh
// Assertion macros for the PI drop controller checker.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef PI_AQM_DROP_CONTROLLER_UNIT_ASSERT_SVH
`define PI_AQM_DROP_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define PIAQM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIAQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/piaqm_pkg.sv
// Shared widths, codes and reset values of the PI drop controller.
// No dependencies; imported by the controller and its checker.
`default_nettype none

package piaqm_pkg;

  localparam int W_ACT  = 2;
  localparam int W_SIZE = 16;
  localparam int W_RND  = 32;
  localparam int W_VERD = 3;
  localparam int W_PROB = 33;
  localparam int W_CNT  = 32;
  localparam int W_CFGI = 3;
  localparam int W_CFGD = 32;
  localparam int W_CTR  = 6;

  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 49;

  localparam logic [W_ACT-1:0] ACT_ENQ  = 2'd0;
  localparam logic [W_ACT-1:0] ACT_DEQ  = 2'd1;
  localparam logic [W_ACT-1:0] ACT_TICK = 2'd2;

  localparam logic [W_VERD-1:0] VERD_ACCEPT = 3'd0;
  localparam logic [W_VERD-1:0] VERD_FORCED = 3'd1;
  localparam logic [W_VERD-1:0] VERD_EARLY  = 3'd2;
  localparam logic [W_VERD-1:0] VERD_DEQ    = 3'd3;
  localparam logic [W_VERD-1:0] VERD_EMPTY  = 3'd4;
  localparam logic [W_VERD-1:0] VERD_TICK   = 3'd5;

  localparam logic [W_CFGI-1:0] CFG_BYTE_MODE = 3'd0;
  localparam logic [W_CFGI-1:0] CFG_MEAN_SIZE = 3'd1;
  localparam logic [W_CFGI-1:0] CFG_QUEUE_REF = 3'd2;
  localparam logic [W_CFGI-1:0] CFG_ALPHA     = 3'd3;
  localparam logic [W_CFGI-1:0] CFG_BETA      = 3'd4;
  localparam logic [W_CFGI-1:0] CFG_LIMIT     = 3'd5;

  localparam logic [15:0] MEAN_RST  = 16'd500;
  localparam logic [31:0] REF_RST   = 32'd3276800;
  localparam logic [31:0] ALPHA_RST = 32'd78254;
  localparam logic [31:0] BETA_RST  = 32'd77997;
  localparam logic [31:0] LIMIT_RST = 32'd50;

  localparam logic [W_PROB-1:0] P_ONE = 33'h1_0000_0000;

endpackage

`default_nettype wire

### design/pi_aqm_drop_controller_unit.sv
// PI active queue management drop controller, top level.
// Depends on piaqm_pkg.
//
// Input channel (in_valid/in_ready) carries one request: enqueue, dequeue
// or sampling tick. Each request gives one result on the output channel
// (out_valid/out_ready); action code 3 is consumed and gives none.
// The block works on one request at a time and drops in_ready from the
// cycle after acceptance until the result is written to the output
// register. Enqueue in byte mode runs 32 multiply steps and 49 divide steps;
// a tick runs two 32-step gain multiplies, plus two 49-step length divides
// in byte mode.
// All arithmetic runs through one shift-add multiplier and one restoring
// divider under the sequencer. A finished result waits in the output
// register while the next request is accepted; if that result has not
// been taken when the next one completes, the sequencer holds.
// Reset (rst, synchronous) restores the register defaults and clears the
// probability, occupancy and counters; in_ready is low during reset.
// Configuration writes take effect at once; make them only while idle.
`default_nettype none

module pi_aqm_drop_controller_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [piaqm_pkg::W_CFGI-1:0]     cfg_index,
  input  logic [piaqm_pkg::W_CFGD-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [piaqm_pkg::W_ACT-1:0]      action,
  input  logic [piaqm_pkg::W_SIZE-1:0]     packet_size,
  input  logic [piaqm_pkg::W_RND-1:0]      random_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [piaqm_pkg::W_VERD-1:0]     verdict,
  output logic [piaqm_pkg::W_PROB-1:0]     drop_probability,
  output logic [piaqm_pkg::W_CNT-1:0]      queued_packets,
  output logic [piaqm_pkg::W_CNT-1:0]      queued_bytes,
  output logic [piaqm_pkg::W_CNT-1:0]      forced_drop_count,
  output logic [piaqm_pkg::W_CNT-1:0]      early_drop_count,
  output logic [piaqm_pkg::W_CNT-1:0]      dequeued_byte_count
);
  import piaqm_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_LEN    = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_ERR    = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_ACC    = 4'd6;
  localparam logic [3:0] ST_CLAMP  = 4'd7;
  localparam logic [3:0] ST_EDROP  = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0] state;

  // configuration
  logic        byte_mode;
  logic [15:0] mean_size;
  logic [31:0] q_ref;
  logic [31:0] alpha;
  logic [31:0] beta;
  logic [31:0] q_limit;

  // controller state
  logic [W_PROB-1:0] drop_prob;
  logic [31:0]       old_len;
  logic [31:0]       pkt_occ;
  logic [31:0]       byte_occ;
  logic [31:0]       forced_cnt;
  logic [31:0]       early_cnt;
  logic [31:0]       deq_bytes;

  // captured request
  logic [W_ACT-1:0]  act;
  logic [W_SIZE-1:0] size;
  logic [W_RND-1:0]  rnd;

  // shared datapath
  logic             phase;
  logic [W_CTR-1:0] ctr;
  logic [15:0]      rem;
  logic [48:0]      dvd;
  logic [48:0]      mcand;
  logic [80:0]      prod;
  logic             err_neg;
  logic [82:0]      acc;
  logic [W_VERD-1:0] verd;

  logic [15:0] emean;
  logic [31:0] cur_len;
  logic [31:0] len_sel;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        div_ge;
  logic [15:0] rem_next;
  logic [49:0] mul_sum;
  logic [49:0] err_diff;
  logic [49:0] err_abs;
  logic [82:0] term;
  logic [82:0] acc_sum;
  logic [W_PROB-1:0] clamp_prob;
  logic [32:0] byte_sum;
  logic        full;
  logic [31:0] byte_sat;
  logic [W_PROB-1:0] p_sat;
  logic        early;
  logic [31:0] byte_left;
  logic        out_free;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    emean   = (mean_size == 16'd0) ? 16'd1 : mean_size;
    cur_len = byte_mode ? byte_occ : pkt_occ;
    len_sel = phase ? old_len : cur_len;

    // restoring divide step
    rem_sh   = {rem, dvd[48]};
    rem_sub  = rem_sh - {1'b0, emean};
    div_ge   = rem_sh >= {1'b0, emean};
    rem_next = div_ge ? rem_sub[15:0] : rem_sh[15:0];

    // shift-add multiply step
    mul_sum = {1'b0, prod[80:32]} + (prod[0] ? {1'b0, mcand} : 50'd0);

    err_diff = {1'b0, dvd} - {18'd0, q_ref};
    err_abs  = err_diff[49] ? (~err_diff + 50'd1) : err_diff;

    // current error adds, previous error subtracts
    term    = {2'b00, prod};
    acc_sum = (err_neg ^ phase) ? (acc - term) : (acc + term);

    if (acc[82]) begin
      clamp_prob = '0;
    end else if (acc[82:16] > {34'd0, P_ONE}) begin
      clamp_prob = P_ONE;
    end else begin
      clamp_prob = acc[48:16];
    end

    byte_sum = {1'b0, byte_occ} + {17'd0, size};
    full     = byte_mode ? (byte_sum > {1'b0, q_limit}) : (pkt_occ >= q_limit);
    byte_sat = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];

    p_sat = (dvd > {16'd0, P_ONE}) ? P_ONE : dvd[32:0];
    early = {1'b0, rnd} <= p_sat;

    byte_left = (byte_occ > {16'd0, size}) ? (byte_occ - {16'd0, size}) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      byte_mode  <= 1'b0;
      mean_size  <= MEAN_RST;
      q_ref      <= REF_RST;
      alpha      <= ALPHA_RST;
      beta       <= BETA_RST;
      q_limit    <= LIMIT_RST;
      drop_prob  <= '0;
      old_len    <= '0;
      pkt_occ    <= '0;
      byte_occ   <= '0;
      forced_cnt <= '0;
      early_cnt  <= '0;
      deq_bytes  <= '0;
      phase      <= 1'b0;
      ctr        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BYTE_MODE: byte_mode <= cfg_data[0];
          CFG_MEAN_SIZE: mean_size <= cfg_data[15:0];
          CFG_QUEUE_REF: q_ref     <= cfg_data;
          CFG_ALPHA:     alpha     <= cfg_data;
          CFG_BETA:      beta      <= cfg_data;
          CFG_LIMIT:     q_limit   <= cfg_data;
          default: ;
        endcase
      end

      // a finishing request reloads the output register itself
      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act   <= action;
            size  <= packet_size;
            rnd   <= random_value;
            state <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          unique case (act)
            ACT_ENQ: begin
              if (full) begin
                forced_cnt <= forced_cnt + 32'd1;
                verd       <= VERD_FORCED;
                state      <= ST_FINISH;
              end else if (byte_mode) begin
                mcand <= {16'd0, drop_prob};
                prod  <= {65'd0, size};
                ctr   <= W_CTR'(MUL_STEPS - 1);
                state <= ST_MUL;
              end else begin
                dvd   <= {16'd0, drop_prob};
                state <= ST_EDROP;
              end
            end
            ACT_DEQ: begin
              if (pkt_occ == 32'd0) begin
                verd <= VERD_EMPTY;
              end else begin
                pkt_occ   <= pkt_occ - 32'd1;
                byte_occ  <= byte_left;
                deq_bytes <= deq_bytes + {16'd0, size};
                verd      <= VERD_DEQ;
              end
              state <= ST_FINISH;
            end
            ACT_TICK: begin
              phase <= 1'b0;
              acc   <= {34'd0, drop_prob, 16'd0};
              state <= ST_LEN;
            end
            default: state <= ST_IDLE;
          endcase
        end

        ST_LEN: begin
          // length in Q32.16; byte mode normalises by the mean size
          dvd <= {1'b0, len_sel, 16'd0};
          rem <= '0;
          if (byte_mode) begin
            ctr   <= W_CTR'(DIV_STEPS - 1);
            state <= ST_DIV;
          end else begin
            state <= ST_ERR;
          end
        end

        ST_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[47:0], div_ge};
          ctr <= ctr - W_CTR'(1);
          if (ctr == '0) begin
            state <= (act == ACT_ENQ) ? ST_EDROP : ST_ERR;
          end
        end

        ST_ERR: begin
          mcand   <= err_abs[48:0];
          err_neg <= err_diff[49];
          prod    <= {49'd0, (phase ? beta : alpha)};
          ctr     <= W_CTR'(MUL_STEPS - 1);
          state   <= ST_MUL;
        end

        ST_MUL: begin
          prod <= {mul_sum, prod[31:1]};
          ctr  <= ctr - W_CTR'(1);
          if (ctr == '0) begin
            state <= ST_ACC;
          end
        end

        ST_ACC: begin
          if (act == ACT_ENQ) begin
            // p * size done, divide by the mean size
            dvd   <= prod[48:0];
            rem   <= '0;
            ctr   <= W_CTR'(DIV_STEPS - 1);
            state <= ST_DIV;
          end else begin
            acc <= acc_sum;
            if (!phase) begin
              phase <= 1'b1;
              state <= ST_LEN;
            end else begin
              state <= ST_CLAMP;
            end
          end
        end

        ST_CLAMP: begin
          drop_prob <= clamp_prob;
          old_len   <= cur_len;
          verd      <= VERD_TICK;
          state     <= ST_FINISH;
        end

        ST_EDROP: begin
          if (early) begin
            early_cnt <= early_cnt + 32'd1;
            verd      <= VERD_EARLY;
          end else begin
            if (pkt_occ != 32'hFFFF_FFFF) begin
              pkt_occ <= pkt_occ + 32'd1;
            end
            byte_occ <= byte_sat;
            verd     <= VERD_ACCEPT;
          end
          state <= ST_FINISH;
        end

        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            verdict             <= verd;
            drop_probability    <= drop_prob;
            queued_packets      <= pkt_occ;
            queued_bytes        <= byte_occ;
            forced_drop_count   <= forced_cnt;
            early_drop_count    <= early_cnt;
            dequeued_byte_count <= deq_bytes;
            out_valid           <= 1'b1;
            state               <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/piaqm_checker.sv
// Port-level checks on the PI drop controller, bound to its top level.
// Depends on piaqm_pkg and pi_aqm_drop_controller_unit_assert.svh.
`default_nettype none

`include "pi_aqm_drop_controller_unit_assert.svh"

module piaqm_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [piaqm_pkg::W_VERD-1:0]     verdict,
  input  logic [piaqm_pkg::W_PROB-1:0]     drop_probability,
  input  logic [piaqm_pkg::W_CNT-1:0]      queued_packets
);
  import piaqm_pkg::*;

  // one request at a time: ready drops after acceptance
  `PIAQM_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")

  // a stalled result holds
  `PIAQM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(drop_probability), "stalled result changed")

  `PIAQM_ASSERT_IMP(a_prob_range, out_valid, drop_probability <= P_ONE, "probability above one")

  `PIAQM_ASSERT_IMP(a_verdict_code, out_valid, verdict <= VERD_TICK, "bad verdict code")

  `PIAQM_ASSERT_IMP(a_empty_zero, out_valid && (verdict == VERD_EMPTY), queued_packets == '0, "empty verdict with packets held")

endmodule

bind pi_aqm_drop_controller_unit piaqm_checker u_piaqm_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .verdict          (verdict),
  .drop_probability (drop_probability),
  .queued_packets   (queued_packets)
);

`default_nettype wire

### dv/pi_aqm_drop_controller_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the PI drop controller: a directed table, then random phases under
// changing register settings, each result checked against a table entry or a local model of the block.
// Depends on piaqm_pkg and pi_aqm_drop_controller_unit.

module pi_aqm_drop_controller_unit_tb;
  import piaqm_pkg::*;

  localparam logic [W_ACT-1:0]  ACT_NONE      = 2'd3;
  localparam logic [W_CFGI-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [W_CFGI-1:0] CFG_UNUSED_HI = 3'd7;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int SETTLE_CYCLES   = 200;
  localparam int LONG_HOLD       = 600;
  localparam int MAX_RUN         = 64;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [W_VERD-1:0] verdict;
    logic [W_PROB-1:0] prob;
    logic [W_CNT-1:0]  pkts;
    logic [W_CNT-1:0]  bytes;
    logic [W_CNT-1:0]  forced;
    logic [W_CNT-1:0]  early;
    logic [W_CNT-1:0]  deq_bytes;
  } aqm_outcome_t;

  typedef struct {
    bit                is_write;
    logic [W_ACT-1:0]  act;
    logic [W_SIZE-1:0] size;
    logic [31:0]       word;
    logic [W_CFGI-1:0] reg_idx;
    bit                typed;
    aqm_outcome_t      want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [W_CFGI-1:0] cfg_index;
  logic [W_CFGD-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [W_ACT-1:0]  action;
  logic [W_SIZE-1:0] packet_size;
  logic [W_RND-1:0]  random_value;
  logic              out_valid;
  logic              out_ready;
  logic [W_VERD-1:0] verdict;
  logic [W_PROB-1:0] drop_probability;
  logic [W_CNT-1:0]  queued_packets;
  logic [W_CNT-1:0]  queued_bytes;
  logic [W_CNT-1:0]  forced_drop_count;
  logic [W_CNT-1:0]  early_drop_count;
  logic [W_CNT-1:0]  dequeued_byte_count;

  // register copies
  bit          shadow_byte_mode = 1'b0;
  logic [15:0] shadow_mean      = MEAN_RST;
  logic [31:0] shadow_qref      = REF_RST;
  logic [31:0] shadow_alpha     = ALPHA_RST;
  logic [31:0] shadow_beta      = BETA_RST;
  logic [31:0] shadow_limit     = LIMIT_RST;

  // controller state copies
  logic [W_PROB-1:0] pi_prob       = '0;
  logic [31:0]       pi_old_len    = '0;
  logic [31:0]       occ_pkts      = '0;
  logic [31:0]       occ_bytes     = '0;
  logic [31:0]       cnt_forced    = '0;
  logic [31:0]       cnt_early     = '0;
  logic [31:0]       cnt_deq_bytes = '0;

  aqm_outcome_t pending_outcomes[$];
  stim_row_t    stim_table[$];
  aqm_outcome_t mon_got;
  aqm_outcome_t mon_want;

  int fail_count    = 0;
  int checked_count = 0;
  int request_count = 0;
  int verdict_seen [8];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_run     = 0;

  pi_aqm_drop_controller_unit uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .action              (action),
    .packet_size         (packet_size),
    .random_value        (random_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .verdict             (verdict),
    .drop_probability    (drop_probability),
    .queued_packets      (queued_packets),
    .queued_bytes        (queued_bytes),
    .forced_drop_count   (forced_drop_count),
    .early_drop_count    (early_drop_count),
    .dequeued_byte_count (dequeued_byte_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [63:0] eff_mean();
    return (shadow_mean == 16'd0) ? 64'd1 : {48'd0, shadow_mean};
  endfunction

  // Q32.16 length in packets minus the reference, sign-extended
  function automatic logic signed [127:0] length_error(input logic [31:0] len);
    logic [63:0] q;
    q = {16'd0, len, 16'd0};
    if (shadow_byte_mode) q = q / eff_mean();
    return $signed({64'd0, q}) - $signed({96'd0, shadow_qref});
  endfunction

  function automatic bit aqm_step(input logic [W_ACT-1:0] act, input logic [W_SIZE-1:0] size,
                                  input logic [W_RND-1:0] rnd, output aqm_outcome_t res);
    logic [63:0]        p_eff;
    logic [32:0]        byte_sum;
    logic [31:0]        cur_len;
    logic signed [127:0] acc;
    logic [W_VERD-1:0]  v;
    bit                 full;
    res = '0;
    v = VERD_TICK;
    case (act)
      ACT_ENQ: begin
        if (shadow_byte_mode) full = ({1'b0, occ_bytes} + size) > {1'b0, shadow_limit};
        else full = occ_pkts >= shadow_limit;
        if (full) begin
          cnt_forced++;
          v = VERD_FORCED;
        end else begin
          p_eff = {31'd0, pi_prob};
          if (shadow_byte_mode) p_eff = (p_eff * size) / eff_mean();
          if (p_eff > {31'd0, P_ONE}) p_eff = {31'd0, P_ONE};
          if ({32'd0, rnd} <= p_eff) begin
            cnt_early++;
            v = VERD_EARLY;
          end else begin
            // saturate occupancy rather than wrap
            if (occ_pkts != '1) occ_pkts++;
            byte_sum = {1'b0, occ_bytes} + size;
            occ_bytes = byte_sum[32] ? '1 : byte_sum[31:0];
            v = VERD_ACCEPT;
          end
        end
      end
      ACT_DEQ: begin
        if (occ_pkts == '0) begin
          v = VERD_EMPTY;
        end else begin
          occ_pkts--;
          occ_bytes = (occ_bytes > size) ? occ_bytes - size : '0;
          cnt_deq_bytes += size;
          v = VERD_DEQ;
        end
      end
      ACT_TICK: begin
        cur_len = shadow_byte_mode ? occ_bytes : occ_pkts;
        // old length is read in the mode now in force
        acc = $signed({79'd0, pi_prob, 16'd0})
            + $signed({96'd0, shadow_alpha}) * length_error(cur_len)
            - $signed({96'd0, shadow_beta}) * length_error(pi_old_len);
        if (acc < 0) pi_prob = '0;
        else if ((acc >>> 16) > $signed({95'd0, P_ONE})) pi_prob = P_ONE;
        else pi_prob = acc[48:16];
        pi_old_len = cur_len;
        v = VERD_TICK;
      end
      default: return 1'b0;
    endcase
    res = '{v, pi_prob, occ_pkts, occ_bytes, cnt_forced, cnt_early, cnt_deq_bytes};
    return 1'b1;
  endfunction

  function automatic void add_request(input logic [W_ACT-1:0] act,
                                      input logic [W_SIZE-1:0] size, input logic [31:0] rnd,
                                      input bit typed = 1'b0, input aqm_outcome_t want = '0);
    stim_row_t r;
    r.is_write = 1'b0;
    r.act      = act;
    r.size     = size;
    r.word     = rnd;
    r.reg_idx  = CFG_BYTE_MODE;
    r.typed    = typed;
    r.want     = want;
    stim_table.push_back(r);
  endfunction

  function automatic void add_write(input logic [W_CFGI-1:0] idx, input logic [31:0] data);
    stim_row_t r;
    r.is_write = 1'b1;
    r.act      = ACT_ENQ;
    r.size     = '0;
    r.word     = data;
    r.reg_idx  = idx;
    r.typed    = 1'b0;
    r.want     = '0;
    stim_table.push_back(r);
  endfunction

  function automatic int sender_gap();
    int g;
    g = 0;
    while (g < MAX_RUN && $urandom_range(99) < send_idle_pct) g++;
    return g;
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      1: begin send_idle_pct = 84; recv_idle_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_idle_pct = 84; end
      3: begin send_idle_pct = 34; recv_idle_pct = 34; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Hold valid from the step of the previous acceptance unless a gap is drawn.
  task automatic send_request(input logic [W_ACT-1:0] act, input logic [W_SIZE-1:0] size,
                              input logic [W_RND-1:0] rnd, input bit typed,
                              input aqm_outcome_t want);
    aqm_outcome_t predicted;
    int           gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    packet_size  <= size;
    random_value <= rnd;
    do @(posedge clk); while (!in_ready);
    request_count++;
    if (aqm_step(act, size, rnd, predicted))
      pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    // a request with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [W_CFGI-1:0] idx, input logic [W_CFGD-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BYTE_MODE: shadow_byte_mode = data[0];
      CFG_MEAN_SIZE: shadow_mean      = data[15:0];
      CFG_QUEUE_REF: shadow_qref      = data;
      CFG_ALPHA:     shadow_alpha     = data;
      CFG_BETA:      shadow_beta      = data;
      CFG_LIMIT:     shadow_limit     = data;
      default: ;
    endcase
  endtask

  task automatic configure_phase(input int ph);
    logic [31:0] meanv;
    logic [31:0] qref;
    logic [31:0] gain_a;
    logic [31:0] gain_b;
    logic [31:0] lim;
    logic [31:0] eff;
    logic [31:0] word;
    bit          bm;
    case (ph)
      2: begin
        bm = 1'b0; meanv = 32'hFFFF; qref = '1; gain_a = '1; gain_b = '1; lim = '1;
      end
      3: begin
        bm = 1'b1; meanv = '0; qref = '0; gain_a = '0; gain_b = '0; lim = '0;
      end
      default: begin
        bm = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0: meanv = '0;
          1: meanv = 32'hFFFF;
          default: meanv = $urandom_range(40, 1500);
        endcase
        eff = (meanv == 0) ? 32'd1 : meanv;
        qref = ($urandom_range(0, 60) << 16) | $urandom_range(0, 16'hFFFF);
        gain_a = $urandom_range(0, 32'h0400_0000);
        gain_b = gain_a - $urandom_range(0, gain_a / 8);
        lim = bm ? $urandom_range(0, 60 * eff) : $urandom_range(0, 60);
        if ($urandom_range(0, 7) == 0) lim = '1;
      end
    endcase
    // upper bits beyond the register width are noise
    word = $urandom();
    word[0] = bm;
    write_register(CFG_BYTE_MODE, word);
    word = $urandom();
    word[15:0] = meanv[15:0];
    write_register(CFG_MEAN_SIZE, word);
    write_register(CFG_QUEUE_REF, qref);
    write_register(CFG_ALPHA, gain_a);
    write_register(CFG_BETA, gain_b);
    write_register(CFG_LIMIT, lim);
    if (ph == 4) begin
      write_register(CFG_UNUSED_LO, $urandom());
      write_register(CFG_UNUSED_HI, $urandom());
    end
  endtask

  task automatic report_failure(input string what, input aqm_outcome_t want,
                                input aqm_outcome_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected: verdict %0d p %h pkts %0d bytes %0d forced %0d early %0d deq %0d",
               want.verdict, want.prob, want.pkts, want.bytes, want.forced, want.early,
               want.deq_bytes);
      $display("  actual:   verdict %0d p %h pkts %0d bytes %0d forced %0d early %0d deq %0d",
               got.verdict, got.prob, got.pkts, got.bytes, got.forced, got.early,
               got.deq_bytes);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      mon_got = {verdict, drop_probability, queued_packets, queued_bytes, forced_drop_count,
                 early_drop_count, dequeued_byte_count};
      verdict_seen[verdict]++;
      if (pending_outcomes.size() == 0) begin
        report_failure("result with no request outstanding", '0, mon_got);
      end else begin
        mon_want = pending_outcomes.pop_front();
        checked_count++;
        if (mon_got !== mon_want) report_failure("result mismatch", mon_want, mon_got);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_run < MAX_RUN && $urandom_range(99) < recv_idle_pct) begin
        stall_run++;
        out_ready <= 1'b0;
      end else begin
        stall_run = 0;
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          ph;
    int          n;
    int          counted;
    int          pick;
    logic [W_ACT-1:0]  act;
    logic [W_SIZE-1:0] size;
    logic [W_RND-1:0]  rnd;
    logic [31:0]       span;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_BYTE_MODE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    action       = ACT_ENQ;
    packet_size  = '0;
    random_value = '0;

    // from reset: empty dequeue, zero probability still drops on zero random
    add_request(ACT_DEQ, 16'd100, 32'd7, 1'b1, '{VERD_EMPTY, '0, 0, 0, 0, 0, 0});
    add_request(ACT_ENQ, 16'hFFFF, 32'd0, 1'b1, '{VERD_EARLY, '0, 0, 0, 0, 1, 0});
    add_request(ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                '{VERD_ACCEPT, '0, 1, 65535, 0, 1, 0});
    add_request(ACT_ENQ, 16'd0, 32'd1, 1'b1, '{VERD_ACCEPT, '0, 2, 65535, 0, 1, 0});
    add_request(ACT_DEQ, 16'hFFFF, 32'd0, 1'b1, '{VERD_DEQ, '0, 1, 0, 0, 1, 65535});
    // departing size above bytes held: bytes floor at zero
    add_request(ACT_DEQ, 16'd100, 32'd0, 1'b1, '{VERD_DEQ, '0, 0, 0, 0, 1, 65635});
    add_request(ACT_TICK, 16'd0, 32'd0, 1'b1, '{VERD_TICK, '0, 0, 0, 0, 1, 65635});
    add_request(ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    add_write(CFG_LIMIT, 32'd0);
    add_request(ACT_ENQ, 16'd1500, 32'hFFFF_FFFF, 1'b1,
                '{VERD_FORCED, '0, 0, 0, 1, 1, 65635});
    // maximum gain: drive probability to one
    add_write(CFG_LIMIT, 32'hFFFF_FFFF);
    add_write(CFG_ALPHA, 32'hFFFF_FFFF);
    add_write(CFG_BETA, 32'd0);
    add_write(CFG_QUEUE_REF, 32'd0);
    add_request(ACT_ENQ, 16'd200, 32'hFFFF_FFFF);
    add_request(ACT_TICK, 16'd0, 32'd0);
    add_request(ACT_TICK, 16'd0, 32'd0);
    add_request(ACT_ENQ, 16'd10, 32'hFFFF_FFFF);
    // byte mode with zero mean size, mode change between ticks
    add_write(CFG_BYTE_MODE, 32'd1);
    add_write(CFG_MEAN_SIZE, 32'd0);
    add_write(CFG_ALPHA, 32'd0);
    add_write(CFG_BETA, 32'hFFFF_FFFF);
    add_request(ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(ACT_TICK, 16'd0, 32'd0);
    add_request(ACT_TICK, 16'd0, 32'd0);
    add_request(ACT_ENQ, 16'hFFFF, 32'd1);
    // byte limit met exactly, then exceeded by one
    add_write(CFG_MEAN_SIZE, 32'hFFFF);
    add_write(CFG_LIMIT, 32'd65835);
    add_request(ACT_ENQ, 16'd100, 32'hFFFF_FFFF);
    add_request(ACT_ENQ, 16'd1, 32'hFFFF_FFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(0);
    foreach (stim_table[i]) begin
      if (stim_table[i].is_write) begin
        drain_results();
        write_register(stim_table[i].reg_idx, stim_table[i].word);
      end else begin
        send_request(stim_table[i].act, stim_table[i].size, stim_table[i].word,
                     stim_table[i].typed, stim_table[i].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      set_idle(ph % 4);
      configure_phase(ph);
      counted = 0;
      n = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // long receiver hold while requests keep coming, later a full pause
        if (ph == 0 && n == 30) hold_requests++;
        if (ph == 0 && n == 90) drain_results();
        pick = $urandom_range(99);
        if (pick < 50) act = ACT_ENQ;
        else if (pick < 80) act = ACT_DEQ;
        else if (pick < 95) act = ACT_TICK;
        else act = ACT_NONE;
        pick = $urandom_range(99);
        span = eff_mean() * 2;
        if (span > 32'hFFFF) span = 32'hFFFF;
        if (pick < 5) size = '0;
        else if (pick < 10) size = '1;
        else if (pick < 55) size = $urandom_range(0, 16'hFFFF);
        else size = $urandom_range(0, span);
        pick = $urandom_range(99);
        if (pick < 80) rnd = $urandom();
        else if (pick < 90) rnd = $urandom_range(0, 1000);
        else if (pi_prob[32]) rnd = $urandom();
        else rnd = pi_prob[31:0] + $urandom_range(0, 2) - 1;
        send_request(act, size, rnd, 1'b0, '0);
        if (act != ACT_NONE) counted++;
        n++;
      end
    end
    drain_results();

    $display("%0d requests accepted (%0d directed rows, %0d random phases), %0d results checked",
             request_count, stim_table.size(), NUM_PHASES, checked_count);
    $display("verdicts: accept %0d forced %0d early %0d dequeue %0d empty %0d tick %0d",
             verdict_seen[VERD_ACCEPT], verdict_seen[VERD_FORCED], verdict_seen[VERD_EARLY],
             verdict_seen[VERD_DEQ], verdict_seen[VERD_EMPTY], verdict_seen[VERD_TICK]);
    if (fail_count == 0 && pending_outcomes.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
